// ===== design/nor_seq_pkg.sv =====
// Shared types, constants and opcodes for the SPI NOR flash request sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none
package nor_seq_pkg;

    localparam int PAGE_SIZE  = 256;
    localparam int MAX_LENGTH = 4096;
    localparam int PAGE_BITS  = $clog2(PAGE_SIZE);
    localparam int ADDR_W     = 24;
    localparam int LEN_W      = 13;
    localparam int CMD_W      = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] OP_READ    = 8'h03;
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_PROGRAM = 8'h02;
    localparam logic [7:0] OP_SECTOR  = 8'h20;
    localparam logic [7:0] OP_BLOCK   = 8'hD8;
    localparam logic [7:0] OP_CHIP    = 8'hC7;
    localparam logic [7:0] OP_NONE    = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_SECTOR = 3'd2,
        CMD_BLOCK  = 3'd3,
        CMD_CHIP   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_REJECT,
        KIND_READ,
        KIND_WRITE,
        KIND_SECTOR,
        KIND_BLOCK,
        KIND_CHIP
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_SEND = 2'd1,
        DIR_RECV = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WREN,
        ST_MAIN
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
    } desc_t;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [ADDR_W-1:0]  txn_address;
        logic               has_address;
        logic [LEN_W-1:0]   data_count;
        dir_t               direction;
        logic               poll_busy;
        logic               rejected;
        logic               last;
    } txn_t;

endpackage
`default_nettype wire

// ===== design/nor_seq_front.sv =====
// Front end: accepts request words and classifies them into descriptors.
// Depends on nor_seq_pkg; feeds nor_seq_fifo.
`default_nettype none
module nor_seq_front import nor_seq_pkg::*; (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CMD_W-1:0]  s_command,
    input  wire logic [ADDR_W-1:0] s_flash_address,
    input  wire logic [LEN_W-1:0]  s_byte_length,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output desc_t                  push_desc
);

    logic too_long;

    assign too_long   = {1'b0, s_byte_length} > (LEN_W+1)'(MAX_LENGTH);
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_desc.addr = s_flash_address;
        push_desc.len  = s_byte_length;
        case (s_command)
            CMD_READ:   push_desc.kind = too_long ? KIND_REJECT : KIND_READ;
            CMD_WRITE:  push_desc.kind = too_long ? KIND_REJECT : KIND_WRITE;
            CMD_SECTOR: push_desc.kind = KIND_SECTOR;
            CMD_BLOCK:  push_desc.kind = KIND_BLOCK;
            CMD_CHIP:   push_desc.kind = KIND_CHIP;
            default:    push_desc.kind = KIND_REJECT;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/nor_seq_fifo.sv =====
// Short descriptor queue between front end and back end.
// Depends on nor_seq_pkg.
`default_nettype none
module nor_seq_fifo import nor_seq_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire desc_t push_desc,
    output logic       pop_valid,
    input  wire logic  pop,
    output desc_t      pop_desc
);

    desc_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule
`default_nettype wire

// ===== design/nor_seq_back.sv =====
// Back end: expands one descriptor into SPI transactions, one per cycle while
// m_ready is high, through a registered output stage. Depends on nor_seq_pkg.
`default_nettype none
module nor_seq_back import nor_seq_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               pop_valid,
    output logic                    pop,
    input  wire desc_t              pop_desc,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_opcode,
    output logic [ADDR_W-1:0]       m_txn_address,
    output logic                    m_has_address,
    output logic [LEN_W-1:0]        m_data_count,
    output logic [1:0]              m_direction,
    output logic                    m_poll_busy,
    output logic                    m_rejected,
    output logic                    m_last
);

    localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_SIZE);

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    txn_t               out_reg, out_next;

    logic               emit_ok, emit;
    logic [LEN_W-1:0]   room, chunk, rem_after;

    assign emit_ok   = !out_valid_reg || m_ready;
    assign room      = PAGE_LEN - LEN_W'(cur_reg[PAGE_BITS-1:0]);
    assign chunk     = (rem_reg < room) ? rem_reg : room;
    assign rem_after = rem_reg - chunk;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    state_next = (pop_desc.kind == KIND_REJECT || pop_desc.kind == KIND_READ)
                                 ? ST_MAIN : ST_WREN;
                end
            end
            ST_WREN: begin
                if (emit_ok) begin
                    state_next = ST_MAIN;
                end
            end
            ST_MAIN: begin
                if (emit_ok) begin
                    state_next = (kind_reg == KIND_WRITE && rem_after != '0) ? ST_WREN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        emit      = 1'b0;
        kind_next = kind_reg;
        cur_next  = cur_reg;
        rem_next  = rem_reg;
        out_next  = out_reg;
        case (state_reg)
            ST_IDLE: begin
                pop = pop_valid;
                if (pop_valid) begin
                    kind_next = pop_desc.kind;
                    cur_next  = pop_desc.addr;
                    rem_next  = pop_desc.len;
                end
            end
            ST_WREN: begin
                emit = emit_ok;
                out_next = '{opcode: OP_WREN, txn_address: '0, has_address: 1'b0,
                             data_count: '0, direction: DIR_NONE, poll_busy: 1'b0,
                             rejected: 1'b0, last: 1'b0};
            end
            ST_MAIN: begin
                emit = emit_ok;
                out_next = '{opcode: OP_NONE, txn_address: '0, has_address: 1'b0,
                             data_count: '0, direction: DIR_NONE, poll_busy: 1'b1,
                             rejected: 1'b0, last: 1'b1};
                case (kind_reg)
                    KIND_REJECT: begin
                        out_next.poll_busy = 1'b0;
                        out_next.rejected  = 1'b1;
                    end
                    KIND_READ: begin
                        out_next.opcode      = OP_READ;
                        out_next.txn_address = cur_reg;
                        out_next.has_address = 1'b1;
                        out_next.data_count  = rem_reg;
                        out_next.direction   = (rem_reg != '0) ? DIR_RECV : DIR_NONE;
                        out_next.poll_busy   = 1'b0;
                    end
                    KIND_WRITE: begin
                        out_next.opcode      = OP_PROGRAM;
                        out_next.txn_address = cur_reg;
                        out_next.has_address = 1'b1;
                        out_next.data_count  = chunk;
                        out_next.direction   = (chunk != '0) ? DIR_SEND : DIR_NONE;
                        out_next.last        = rem_after == '0;
                        if (emit_ok) begin
                            cur_next = cur_reg + ADDR_W'(chunk);
                            rem_next = rem_after;
                        end
                    end
                    KIND_SECTOR: begin
                        out_next.opcode      = OP_SECTOR;
                        out_next.txn_address = cur_reg;
                        out_next.has_address = 1'b1;
                    end
                    KIND_BLOCK: begin
                        out_next.opcode      = OP_BLOCK;
                        out_next.txn_address = cur_reg;
                        out_next.has_address = 1'b1;
                    end
                    default: begin
                        out_next.opcode = OP_CHIP;
                    end
                endcase
            end
            default: ;
        endcase
        if (!emit) begin
            out_next = out_reg;
        end
        out_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        cur_reg  <= cur_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_opcode      = out_reg.opcode;
    assign m_txn_address = out_reg.txn_address;
    assign m_has_address = out_reg.has_address;
    assign m_data_count  = out_reg.data_count;
    assign m_direction   = out_reg.direction;
    assign m_poll_busy   = out_reg.poll_busy;
    assign m_rejected    = out_reg.rejected;
    assign m_last        = out_reg.last;

endmodule
`default_nettype wire

// ===== design/spi_nor_flash_op_sequencer_core.sv =====
// Top level of the SPI NOR flash request sequencer.
// Instantiates nor_seq_front, nor_seq_fifo and nor_seq_back; uses nor_seq_pkg.
//
// Usage:
//   The s_ channel takes one request word (command, flash_address,
//   byte_length) per valid/ready handshake. The m_ channel returns the SPI
//   transactions for that request in order, one word per transaction, with
//   m_last high on the final one. Refused requests (unknown command, or a
//   read or write longer than MAX_LENGTH) give one word with m_rejected set.
//   With the queue empty, a request is written into the queue, loaded by
//   the back end and emitted through the output register. Throughput: the
//   back end loads a request in its idle state and then emits one
//   transaction per cycle while m_ready is high; a request has up to 34
//   transactions (a 4096-byte unaligned write). The two-entry request
//   queue lets the front end take new words while the back end is busy.
//   Reset clears the queue, the sequencer state and the output valid; no
//   clearing pass is needed. When the receiver holds m_ready low, the output
//   register holds its word, the sequencer stops, and once the queue fills
//   s_ready drops.
`default_nettype none
module spi_nor_flash_op_sequencer_core import nor_seq_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CMD_W-1:0]  s_command,
    input  wire logic [ADDR_W-1:0] s_flash_address,
    input  wire logic [LEN_W-1:0]  s_byte_length,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_opcode,
    output logic [ADDR_W-1:0]      m_txn_address,
    output logic                   m_has_address,
    output logic [LEN_W-1:0]       m_data_count,
    output logic [1:0]             m_direction,
    output logic                   m_poll_busy,
    output logic                   m_rejected,
    output logic                   m_last
);

    logic  push_valid, push_ready, pop_valid, pop;
    desc_t push_desc, pop_desc;

    nor_seq_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_flash_address (s_flash_address),
        .s_byte_length   (s_byte_length),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_desc       (push_desc)
    );

    nor_seq_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc)
    );

    nor_seq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_desc      (pop_desc),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_opcode      (m_opcode),
        .m_txn_address (m_txn_address),
        .m_has_address (m_has_address),
        .m_data_count  (m_data_count),
        .m_direction   (m_direction),
        .m_poll_busy   (m_poll_busy),
        .m_rejected    (m_rejected),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

// ===== tb/tb_spi_nor_flash_op_sequencer_core.sv =====
// Testbench for spi_nor_flash_op_sequencer_core: drives flash requests, predicts the SPI
// transaction words for each and checks every returned word field by field, in order.
// Depends on nor_seq_pkg and the sequencer RTL only.
`default_nettype none
module tb_spi_nor_flash_op_sequencer_core;
    import nor_seq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_TOP = 24'hFF_FFFF;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command = '0;
    logic [ADDR_W-1:0] s_flash_address = '0;
    logic [LEN_W-1:0]  s_byte_length = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_opcode;
    logic [ADDR_W-1:0] m_txn_address;
    logic              m_has_address;
    logic [LEN_W-1:0]  m_data_count;
    logic [1:0]        m_direction;
    logic              m_poll_busy;
    logic              m_rejected;
    logic              m_last;

    txn_t pending_txns[$];
    int   mismatch_count = 0;
    bit   source_idle_on = 1'b1;
    bit   sink_idle_on = 1'b1;
    int   ready_hold = 0;

    spi_nor_flash_op_sequencer_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_flash_address (s_flash_address),
        .s_byte_length   (s_byte_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_opcode        (m_opcode),
        .m_txn_address   (m_txn_address),
        .m_has_address   (m_has_address),
        .m_data_count    (m_data_count),
        .m_direction     (m_direction),
        .m_poll_busy     (m_poll_busy),
        .m_rejected      (m_rejected),
        .m_last          (m_last)
    );

    always #5 aclk = ~aclk;

    function automatic txn_t txn_word(logic [7:0] op, logic [ADDR_W-1:0] addr, logic has_addr,
                                      logic [LEN_W-1:0] count, dir_t dir, logic poll,
                                      logic rej, logic lst);
        txn_t t;
        t.opcode      = op;
        t.txn_address = addr;
        t.has_address = has_addr;
        t.data_count  = count;
        t.direction   = dir;
        t.poll_busy   = poll;
        t.rejected    = rej;
        t.last        = lst;
        return t;
    endfunction

    function automatic void predict_transactions(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                                 logic [LEN_W-1:0] len);
        int remaining;
        int cur;
        int room;
        int chunk;
        if (cmd > CMD_CHIP || ((cmd == CMD_READ || cmd == CMD_WRITE) && len > MAX_LENGTH)) begin
            pending_txns.push_back(txn_word(OP_NONE, '0, 1'b0, '0, DIR_NONE, 1'b0, 1'b1, 1'b1));
        end else if (cmd == CMD_READ) begin
            pending_txns.push_back(txn_word(OP_READ, addr, 1'b1, len,
                                            (len != 0) ? DIR_RECV : DIR_NONE,
                                            1'b0, 1'b0, 1'b1));
        end else if (cmd == CMD_WRITE) begin
            remaining = len;
            cur = addr;
            do begin
                room = PAGE_SIZE - (cur % PAGE_SIZE);
                chunk = (remaining < room) ? remaining : room;
                remaining -= chunk;
                pending_txns.push_back(txn_word(OP_WREN, '0, 1'b0, '0, DIR_NONE,
                                                1'b0, 1'b0, 1'b0));
                pending_txns.push_back(txn_word(OP_PROGRAM, cur[ADDR_W-1:0], 1'b1,
                                                chunk[LEN_W-1:0],
                                                (chunk != 0) ? DIR_SEND : DIR_NONE,
                                                1'b1, 1'b0, remaining == 0));
                cur = (cur + chunk) % (1 << ADDR_W);
            end while (remaining != 0);
        end else begin
            pending_txns.push_back(txn_word(OP_WREN, '0, 1'b0, '0, DIR_NONE, 1'b0, 1'b0, 1'b0));
            if (cmd == CMD_SECTOR)
                pending_txns.push_back(txn_word(OP_SECTOR, addr, 1'b1, '0, DIR_NONE,
                                                1'b1, 1'b0, 1'b1));
            else if (cmd == CMD_BLOCK)
                pending_txns.push_back(txn_word(OP_BLOCK, addr, 1'b1, '0, DIR_NONE,
                                                1'b1, 1'b0, 1'b1));
            else
                pending_txns.push_back(txn_word(OP_CHIP, '0, 1'b0, '0, DIR_NONE,
                                                1'b1, 1'b0, 1'b1));
        end
    endfunction

    function automatic int idle_len(bit on);
        int r;
        r = $urandom_range(0, 15);
        if (!on || r < 8)
            return 0;
        if (r < 15)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Hold the word until accepted; returns at the falling edge after the handshake.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                logic [LEN_W-1:0] len);
        int gap;
        gap = idle_len(source_idle_on);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_command = cmd;
        s_flash_address = addr;
        s_byte_length = len;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_transactions(cmd, addr, len);
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid = 1'b0;
        wait (pending_txns.size() == 0);
        @(negedge aclk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)  return CMD_WRITE;
        if (r < 12) return CMD_READ;
        if (r < 14) return CMD_SECTOR;
        if (r < 16) return CMD_BLOCK;
        if (r < 18) return CMD_CHIP;
        return $urandom_range(CMD_RSVD_A, CMD_RSVD_C);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [31:0] v;
        logic [31:0] a;
        v = $urandom();
        case ($urandom_range(0, 7))
            4: return {v[23:8], 4'hF, v[3:0]};
            5: return {v[23:8], 8'h00};
            6: begin
                a = ADDR_TOP - $urandom_range(0, 600);
                return a[ADDR_W-1:0];
            end
            7: begin
                a = $urandom_range(0, 600);
                return a[ADDR_W-1:0];
            end
            default: return v[ADDR_W-1:0];
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        logic [31:0] n;
        case ($urandom_range(0, 15))
            9, 10:   n = PAGE_SIZE * $urandom_range(0, MAX_LENGTH / PAGE_SIZE);
            11:      n = $urandom_range(MAX_LENGTH - 6, MAX_LENGTH + 4);
            12:      n = $urandom_range(MAX_LENGTH + 1, (1 << LEN_W) - 1);
            13:      n = $urandom_range(0, MAX_LENGTH);
            14:      n = 0;
            15:      n = $urandom_range(1, (1 << LEN_W) - 1);
            default: n = $urandom_range(0, 600);
        endcase
        return n[LEN_W-1:0];
    endfunction

    task automatic send_random_requests(int count);
        repeat (count) send_request(pick_command(), pick_address(), pick_length());
    endtask

    task automatic test_directed_cases();
        send_request(CMD_READ,   24'h00_0000, 13'd0);
        send_request(CMD_READ,   ADDR_TOP,    13'd1);
        send_request(CMD_READ,   ADDR_TOP,    13'd4096);
        send_request(CMD_READ,   24'h12_3456, 13'd4097);
        send_request(CMD_READ,   24'h00_0000, 13'h1FFF);
        send_request(CMD_WRITE,  24'h00_0000, 13'd0);
        send_request(CMD_WRITE,  24'h00_0100, 13'd256);
        send_request(CMD_WRITE,  24'h00_0000, 13'd4096);
        send_request(CMD_WRITE,  24'h00_00FF, 13'd4096);
        send_request(CMD_WRITE,  24'hFF_FFF0, 13'd32);
        send_request(CMD_WRITE,  ADDR_TOP,    13'd1);
        send_request(CMD_WRITE,  24'h00_0080, 13'd128);
        send_request(CMD_WRITE,  24'h00_0010, 13'd4097);
        send_request(CMD_WRITE,  ADDR_TOP,    13'h1FFF);
        send_request(CMD_SECTOR, 24'hAB_CDEF, 13'h1FFF);
        send_request(CMD_SECTOR, 24'h00_0000, 13'd0);
        send_request(CMD_BLOCK,  ADDR_TOP,    13'd4097);
        send_request(CMD_BLOCK,  24'h01_0000, 13'd0);
        send_request(CMD_CHIP,   ADDR_TOP,    13'h1FFF);
        send_request(CMD_CHIP,   24'h00_0000, 13'd0);
        send_request(CMD_RSVD_A, 24'h55_AA55, 13'd10);
        send_request(CMD_RSVD_A + 3'd1, ADDR_TOP, 13'h1FFF);
        send_request(CMD_RSVD_C, 24'h00_0000, 13'd0);
    endtask

    task automatic test_back_to_back();
        source_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        send_random_requests(40);
        source_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_random_idling();
        send_random_requests(210);
    endtask

    task automatic test_drain_pauses();
        for (int i = 0; i < 40; i++) begin
            send_request(pick_command(), pick_address(), pick_length());
            if (i % 4 == 3)
                pause_until_drained();
        end
    endtask

    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
        end else if (!sink_idle_on || $urandom_range(0, 3) != 0) begin
            m_ready = 1'b1;
            ready_hold = $urandom_range(0, 5);
        end else begin
            m_ready = 1'b0;
            ready_hold = idle_len(1'b1);
        end
    end

    always @(posedge aclk) begin
        txn_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_txns.size() == 0) begin
                report_mismatch($sformatf("unexpected word, opcode %02h", m_opcode));
            end else begin
                want = pending_txns.pop_front();
                compare_field("opcode",      m_opcode,      want.opcode);
                compare_field("txn_address", m_txn_address, want.txn_address);
                compare_field("has_address", m_has_address, want.has_address);
                compare_field("data_count",  m_data_count,  want.data_count);
                compare_field("direction",   m_direction,   want.direction);
                compare_field("poll_busy",   m_poll_busy,   want.poll_busy);
                compare_field("rejected",    m_rejected,    want.rejected);
                compare_field("last",        m_last,        want.last);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_back_to_back();
        test_random_idling();
        test_drain_pauses();
        s_valid = 1'b0;
        wait (pending_txns.size() == 0);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_txns.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
design/nor_seq_pkg.sv
design/nor_seq_front.sv
design/nor_seq_fifo.sv
design/nor_seq_back.sv
design/spi_nor_flash_op_sequencer_core.sv
tb/tb_spi_nor_flash_op_sequencer_core.sv
